### design/mrfr_pkg.sv
package mrfr_pkg;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_ERROR = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REASON_NONE  = 2'd0,
        REASON_SHORT = 2'd1,
        REASON_ADDR  = 2'd2,
        REASON_CRC   = 2'd3
    } reason_t;

    localparam logic CFG_OWN_ADDR = 1'b0;
    localparam logic CFG_SILENCE  = 1'b1;

    localparam logic [7:0]  MIN_FRAME   = 8'd6;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [15:0] IDLE_MAX    = 16'hFFFF;

    typedef struct packed {
        opcode_t    opcode;
        logic [7:0] rx_data;
    } item_t;

    typedef struct packed {
        kind_t      result_kind;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [7:0] frame_length;
        reason_t    reject_reason;
    } result_t;

    // CRC-16/MODBUS, reflected, one byte
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### design/mrfr_in_reg.sv
module mrfr_in_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  mrfr_pkg::item_t     s_item,
    input  logic                out_free,
    output mrfr_pkg::item_t     item,
    output logic                item_valid
);

    logic            valid_reg;
    logic            valid_next;
    mrfr_pkg::item_t item_reg;
    logic            take;

    assign s_tready   = !valid_reg || out_free;
    assign take       = s_tvalid && s_tready;
    // the held word is consumed whenever the result side is free
    assign valid_next = take ? 1'b1 : (out_free ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= s_item;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

### design/mrfr_frame_core.sv
module mrfr_frame_core
#(
    parameter int BUF_LEN = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                proc,
    input  mrfr_pkg::item_t     item,
    input  logic [7:0]          own_address,
    input  logic [15:0]         silence_ticks,
    output logic                res_valid,
    output mrfr_pkg::result_t   res
);

    localparam int CNT_W = $clog2(BUF_LEN);

    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [15:0]      running_crc_reg, running_crc_next;
    logic [15:0]      held_tail_reg, held_tail_next;
    logic [7:0]       first_byte_reg, first_byte_next;
    logic [15:0]      idle_count_reg, idle_count_next;

    logic [8:0]       count_inc;
    logic [15:0]      idle_inc;
    logic [7:0]       count_ext;
    logic             close;
    mrfr_pkg::reason_t reason;

    assign count_ext = 8'(byte_count_reg);
    assign count_inc = 9'(byte_count_reg) + 9'd1;
    assign idle_inc  = (idle_count_reg == mrfr_pkg::IDLE_MAX) ? idle_count_reg
                                                              : idle_count_reg + 16'd1;
    assign close     = (byte_count_reg != '0) && (idle_inc > silence_ticks);

    always_comb
    begin
        priority if (count_ext <= mrfr_pkg::MIN_FRAME)
        begin
            reason = mrfr_pkg::REASON_SHORT;
        end
        else if (first_byte_reg != own_address)
        begin
            reason = mrfr_pkg::REASON_ADDR;
        end
        else if (held_tail_reg != running_crc_reg)
        begin
            reason = mrfr_pkg::REASON_CRC;
        end
        else
        begin
            reason = mrfr_pkg::REASON_NONE;
        end
    end

    always_comb
    begin
        byte_count_next  = byte_count_reg;
        running_crc_next = running_crc_reg;
        held_tail_next   = held_tail_reg;
        first_byte_next  = first_byte_reg;
        idle_count_next  = idle_count_reg;
        res_valid        = 1'b0;
        res              = '0;
        if (proc)
        begin
            unique case (item.opcode)
                mrfr_pkg::OP_BYTE:
                begin
                    if (byte_count_reg == '0)
                    begin
                        first_byte_next = item.rx_data;
                    end
                    if (count_ext >= 8'd2)
                    begin
                        running_crc_next = mrfr_pkg::crc_fold(running_crc_reg,
                                                              held_tail_reg[7:0]);
                    end
                    held_tail_next = {item.rx_data, held_tail_reg[15:8]};
                    // buffer full: restart the frame empty
                    if (count_inc >= 9'(BUF_LEN))
                    begin
                        byte_count_next  = '0;
                        running_crc_next = mrfr_pkg::CRC_INIT;
                        held_tail_next   = '0;
                        first_byte_next  = '0;
                    end
                    else
                    begin
                        byte_count_next = CNT_W'(count_inc);
                    end
                    idle_count_next   = '0;
                    res_valid         = 1'b1;
                    res.result_kind   = mrfr_pkg::KIND_DATA;
                    res.data_byte     = item.rx_data;
                    res.byte_index    = count_ext;
                    res.reject_reason = mrfr_pkg::REASON_NONE;
                end
                mrfr_pkg::OP_TICK:
                begin
                    idle_count_next = idle_inc;
                    if (close)
                    begin
                        byte_count_next   = '0;
                        running_crc_next  = mrfr_pkg::CRC_INIT;
                        held_tail_next    = '0;
                        first_byte_next   = '0;
                        res_valid         = 1'b1;
                        res.result_kind   = (reason == mrfr_pkg::REASON_NONE)
                                            ? mrfr_pkg::KIND_ACCEPT : mrfr_pkg::KIND_REJECT;
                        res.frame_length  = count_ext;
                        res.reject_reason = reason;
                    end
                end
                mrfr_pkg::OP_ERROR:
                begin
                    // drop the open frame, keep the idle count
                    byte_count_next  = '0;
                    running_crc_next = mrfr_pkg::CRC_INIT;
                    held_tail_next   = '0;
                    first_byte_next  = '0;
                end
                default:
                begin
                    byte_count_next = byte_count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            running_crc_reg <= mrfr_pkg::CRC_INIT;
            held_tail_reg   <= '0;
            first_byte_reg  <= '0;
            idle_count_reg  <= '0;
        end
        else
        begin
            byte_count_reg  <= byte_count_next;
            running_crc_reg <= running_crc_next;
            held_tail_reg   <= held_tail_next;
            first_byte_reg  <= first_byte_next;
            idle_count_reg  <= idle_count_next;
        end
    end

endmodule

### design/mrfr_out_reg.sv
module mrfr_out_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  mrfr_pkg::result_t   res,
    input  logic                m_tready,
    output logic                m_tvalid,
    output mrfr_pkg::result_t   result,
    output logic                out_free
);

    logic              valid_reg;
    logic              valid_next;
    mrfr_pkg::result_t result_reg;

    assign out_free   = !valid_reg || m_tready;
    assign valid_next = load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign result   = result_reg;

endmodule

### design/modbus_rtu_frame_receiver_core.sv
// Channel   Dir  tdata (low bit up)                                  tuser
// s_*       in   rx_data[7:0]                                        opcode[1:0]
// m_*       out  data_byte, byte_index, frame_length, reject_reason  result_kind[1:0]
// cfg_*     in   index 0 own_address, index 1 silence_ticks          -
//
// One word per cycle unless the output stalls: an input register, a combinational
// update of the frame state (CRC fold included), and a result register.
// The output register stalls on m_tready; s_tready drops only when both the
// input and output registers are held.
// Reset: frame empty, CRC 0xFFFF, idle count 0, own_address 1, silence_ticks 4.
module modbus_rtu_frame_receiver_core
#(
    parameter int BUF_LEN = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_data[7:0]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // data_byte[7:0], byte_index[15:8], frame_length[23:16], reject_reason[25:24]
    output logic [31:0] m_tdata,
    output logic [1:0]  m_tuser,   // result_kind[1:0]
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic [7:0]        own_address_reg;
    logic [15:0]       silence_ticks_reg;
    mrfr_pkg::item_t   s_item;
    mrfr_pkg::item_t   item;
    logic              item_valid;
    logic              out_free;
    logic              proc;
    logic              res_valid;
    mrfr_pkg::result_t res;
    mrfr_pkg::result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg   <= 8'd1;
            silence_ticks_reg <= 16'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mrfr_pkg::CFG_OWN_ADDR: own_address_reg   <= cfg_data[7:0];
                mrfr_pkg::CFG_SILENCE:  silence_ticks_reg <= cfg_data;
                default:                own_address_reg   <= own_address_reg;
            endcase
        end
    end

    assign s_item.opcode  = mrfr_pkg::opcode_t'(s_tuser);
    assign s_item.rx_data = s_tdata;

    mrfr_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .out_free   (out_free),
        .item       (item),
        .item_valid (item_valid)
    );

    assign proc = item_valid && out_free;

    mrfr_frame_core #(.BUF_LEN(BUF_LEN)) u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .proc          (proc),
        .item          (item),
        .own_address   (own_address_reg),
        .silence_ticks (silence_ticks_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    mrfr_out_reg u_out_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_valid),
        .res      (res),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .result   (result),
        .out_free (out_free)
    );

    assign m_tdata = {6'd0, result.reject_reason, result.frame_length,
                      result.byte_index, result.data_byte};
    assign m_tuser = result.result_kind;

    a_verdict_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != mrfr_pkg::KIND_DATA) |-> (m_tdata[23:16] != 8'd0))
        else $error("verdict with empty frame");

    a_accept_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == mrfr_pkg::KIND_ACCEPT)
        |-> (m_tdata[25:24] == mrfr_pkg::REASON_NONE) && (m_tdata[23:16] > mrfr_pkg::MIN_FRAME))
        else $error("accepted frame too short or with reason");

    a_reject_reason: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == mrfr_pkg::KIND_REJECT)
                      == (m_tdata[25:24] != mrfr_pkg::REASON_NONE)))
        else $error("reject kind and reason disagree");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> out_free)
        else $error("result produced while output register held");

endmodule
